// ----- rtl/tcc_pkg.sv -----
// tcc_pkg: field widths, mode and status codes, item and result types
// and calendar helper functions for the time and calendar counter
// no dependencies
`default_nettype none

package tcc_pkg;

  localparam int MODE_W   = 2;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int MON_W    = 4;
  localparam int DAY_W    = 5;
  localparam int YEAR_W   = 14;
  localparam int STATUS_W = 3;
  localparam int RES_W    = 5;

  localparam logic [MODE_W-1:0] MODE_TICK = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_DAY  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_LOAD = MODE_W'(2);

  localparam logic [STATUS_W-1:0] ST_OK       = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_BAD_HOUR = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_BAD_MIN  = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_BAD_SEC  = STATUS_W'(3);
  localparam logic [STATUS_W-1:0] ST_BAD_MON  = STATUS_W'(4);
  localparam logic [STATUS_W-1:0] ST_BAD_DAY  = STATUS_W'(5);

  localparam logic [HOUR_W-1:0] HOUR_MAX  = HOUR_W'(23);
  localparam logic [MIN_W-1:0]  MIN_MAX   = MIN_W'(59);
  localparam logic [SEC_W-1:0]  SEC_MAX   = SEC_W'(59);
  localparam logic [MON_W-1:0]  MON_FIRST = MON_W'(1);
  localparam logic [MON_W-1:0]  MON_LAST  = MON_W'(12);
  localparam logic [DAY_W-1:0]  DAY_FIRST = DAY_W'(1);
  localparam logic [YEAR_W-1:0] YEAR_MAX  = '1;
  localparam logic [YEAR_W-1:0] YEAR_RST  = YEAR_W'(2000);

  // year residue modulo 25, used for the century rules
  localparam logic [RES_W-1:0] RES_LAST = RES_W'(24);
  localparam logic [RES_W-1:0] RES_RST  = RES_W'(0);

  // floor(y / 25) == (y * RECIP25) >> RECIP_SHIFT for every 14-bit y
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 17;
  localparam int PROD_W      = YEAR_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP25 = RECIP_W'(5243);

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [HOUR_W-1:0] load_hour;
    logic [MIN_W-1:0]  load_minute;
    logic [SEC_W-1:0]  load_second;
    logic [MON_W-1:0]  load_month;
    logic [DAY_W-1:0]  load_day;
    logic [YEAR_W-1:0] load_year;
    logic [RES_W-1:0]  load_res;
  } item_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   cur_hour;
    logic [MIN_W-1:0]    cur_minute;
    logic [SEC_W-1:0]    cur_second;
    logic [MON_W-1:0]    cur_month;
    logic [DAY_W-1:0]    cur_day;
    logic [YEAR_W-1:0]   cur_year;
    logic [STATUS_W-1:0] status;
    logic                day_changed;
  } result_t;

  function automatic logic [RES_W-1:0] year_mod25(input logic [YEAR_W-1:0] y);
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] q;
    logic [YEAR_W-1:0] qx;
    logic [YEAR_W-1:0] r;
    prod = PROD_W'(y) * PROD_W'(RECIP25);
    q    = prod[PROD_W-1:RECIP_SHIFT];
    qx   = YEAR_W'(q);
    r    = y - (qx << 4) - (qx << 3) - qx;
    return r[RES_W-1:0];
  endfunction

  function automatic logic is_leap(input logic [YEAR_W-1:0] y,
                                   input logic [RES_W-1:0]  res);
    return (y[1:0] == 2'b00) && ((res != RES_W'(0)) || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] mon,
                                                  input logic             leap);
    logic [DAY_W-1:0] n;
    case (mon)
      MON_W'(1), MON_W'(3), MON_W'(5), MON_W'(7),
      MON_W'(8), MON_W'(10), MON_W'(12): n = DAY_W'(31);
      MON_W'(4), MON_W'(6), MON_W'(9), MON_W'(11): n = DAY_W'(30);
      MON_W'(2): n = leap ? DAY_W'(29) : DAY_W'(28);
      default: n = DAY_W'(0);
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tcc_if.sv -----
// tcc_in_if and tcc_out_if: valid/ready channels for input items and results
// depends on tcc_pkg
`default_nettype none

interface tcc_in_if;
  import tcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [HOUR_W-1:0] load_hour;
  logic [MIN_W-1:0]  load_minute;
  logic [SEC_W-1:0]  load_second;
  logic [MON_W-1:0]  load_month;
  logic [DAY_W-1:0]  load_day;
  logic [YEAR_W-1:0] load_year;

  modport source (output valid, mode, load_hour, load_minute, load_second,
                  load_month, load_day, load_year, input ready);
  modport sink (input valid, mode, load_hour, load_minute, load_second,
                load_month, load_day, load_year, output ready);
endinterface

interface tcc_out_if;
  import tcc_pkg::*;
  logic                valid;
  logic                ready;
  logic [HOUR_W-1:0]   cur_hour;
  logic [MIN_W-1:0]    cur_minute;
  logic [SEC_W-1:0]    cur_second;
  logic [MON_W-1:0]    cur_month;
  logic [DAY_W-1:0]    cur_day;
  logic [YEAR_W-1:0]   cur_year;
  logic [STATUS_W-1:0] status;
  logic                day_changed;

  modport source (output valid, cur_hour, cur_minute, cur_second, cur_month,
                  cur_day, cur_year, status, day_changed, input ready);
  modport sink (input valid, cur_hour, cur_minute, cur_second, cur_month,
                cur_day, cur_year, status, day_changed, output ready);
endinterface

`default_nettype wire

// ----- rtl/tcc_in_stage.sv -----
// tcc_in_stage: input register for one item, with the mod-25 residue of
// the load year worked out on the way in; depends on tcc_pkg, tcc_in_if
`default_nettype none

module tcc_in_stage (
  input  logic            clk,
  input  logic            rst,
  tcc_in_if.sink          item_in,
  input  logic            advance,
  output logic            s1_valid,
  output tcc_pkg::item_t  s1_item
);
  import tcc_pkg::*;

  logic take;

  assign item_in.ready = !s1_valid || advance;
  assign take          = item_in.valid && item_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item.mode        <= item_in.mode;
      s1_item.load_hour   <= item_in.load_hour;
      s1_item.load_minute <= item_in.load_minute;
      s1_item.load_second <= item_in.load_second;
      s1_item.load_month  <= item_in.load_month;
      s1_item.load_day    <= item_in.load_day;
      s1_item.load_year   <= item_in.load_year;
      s1_item.load_res    <= year_mod25(item_in.load_year);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tcc_calc.sv -----
// tcc_calc: time and date state, next-state logic for tick, day advance
// and load, and the result register; depends on tcc_pkg, tcc_out_if
`default_nettype none

module tcc_calc (
  input  logic            clk,
  input  logic            rst,
  input  logic            s1_valid,
  input  tcc_pkg::item_t  s1_item,
  output logic            advance,
  tcc_out_if.source       result_out
);
  import tcc_pkg::*;

  logic [HOUR_W-1:0] hour, hour_next;
  logic [MIN_W-1:0]  minute, minute_next;
  logic [SEC_W-1:0]  second, second_next;
  logic [MON_W-1:0]  month, month_next;
  logic [DAY_W-1:0]  day, day_next;
  logic [YEAR_W-1:0] year, year_next;
  logic [RES_W-1:0]  year_res, year_res_next;

  logic [MON_W-1:0]  adv_month;
  logic [DAY_W-1:0]  adv_day;
  logic [YEAR_W-1:0] adv_year;
  logic [RES_W-1:0]  adv_res;
  logic [DAY_W-1:0]  last_day;
  logic [DAY_W-1:0]  load_last;

  logic [STATUS_W-1:0] status;
  logic                changed;
  logic                out_valid;
  result_t             result;

  assign advance = s1_valid && (!out_valid || result_out.ready);

  // next date after the held one
  always_comb begin
    last_day  = month_days(month, is_leap(year, year_res));
    adv_day   = day + DAY_W'(1);
    adv_month = month;
    adv_year  = year;
    adv_res   = year_res;
    if (day >= last_day) begin
      adv_day = DAY_FIRST;
      if (month >= MON_LAST) begin
        adv_month = MON_FIRST;
        adv_year  = year + YEAR_W'(1);
        if (year == YEAR_MAX || year_res == RES_LAST) begin
          adv_res = RES_W'(0);
        end else begin
          adv_res = year_res + RES_W'(1);
        end
      end else begin
        adv_month = month + MON_W'(1);
      end
    end
  end

  always_comb begin
    hour_next     = hour;
    minute_next   = minute;
    second_next   = second;
    month_next    = month;
    day_next      = day;
    year_next     = year;
    year_res_next = year_res;
    status        = ST_OK;
    changed       = 1'b0;
    load_last     = month_days(s1_item.load_month,
                               is_leap(s1_item.load_year, s1_item.load_res));
    unique case (s1_item.mode)
      MODE_TICK: begin
        if (second >= SEC_MAX) begin
          second_next = '0;
          if (minute >= MIN_MAX) begin
            minute_next = '0;
            if (hour >= HOUR_MAX) begin
              hour_next     = '0;
              month_next    = adv_month;
              day_next      = adv_day;
              year_next     = adv_year;
              year_res_next = adv_res;
              changed       = 1'b1;
            end else begin
              hour_next = hour + HOUR_W'(1);
            end
          end else begin
            minute_next = minute + MIN_W'(1);
          end
        end else begin
          second_next = second + SEC_W'(1);
        end
      end
      MODE_DAY: begin
        month_next    = adv_month;
        day_next      = adv_day;
        year_next     = adv_year;
        year_res_next = adv_res;
        changed       = 1'b1;
      end
      MODE_LOAD: begin
        priority if (s1_item.load_hour > HOUR_MAX) begin
          status = ST_BAD_HOUR;
        end else if (s1_item.load_minute > MIN_MAX) begin
          status = ST_BAD_MIN;
        end else if (s1_item.load_second > SEC_MAX) begin
          status = ST_BAD_SEC;
        end else if (s1_item.load_month < MON_FIRST || s1_item.load_month > MON_LAST) begin
          status = ST_BAD_MON;
        end else if (s1_item.load_day < DAY_FIRST || s1_item.load_day > load_last) begin
          status = ST_BAD_DAY;
        end else begin
          status = ST_OK;
        end
        if (status == ST_OK) begin
          changed       = (s1_item.load_month != month) || (s1_item.load_day != day) ||
                          (s1_item.load_year != year);
          hour_next     = s1_item.load_hour;
          minute_next   = s1_item.load_minute;
          second_next   = s1_item.load_second;
          month_next    = s1_item.load_month;
          day_next      = s1_item.load_day;
          year_next     = s1_item.load_year;
          year_res_next = s1_item.load_res;
        end
      end
      default: begin
        changed = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour     <= '0;
      minute   <= '0;
      second   <= '0;
      month    <= MON_FIRST;
      day      <= DAY_FIRST;
      year     <= YEAR_RST;
      year_res <= RES_RST;
    end else if (advance) begin
      hour     <= hour_next;
      minute   <= minute_next;
      second   <= second_next;
      month    <= month_next;
      day      <= day_next;
      year     <= year_next;
      year_res <= year_res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.cur_hour    <= hour_next;
      result.cur_minute  <= minute_next;
      result.cur_second  <= second_next;
      result.cur_month   <= month_next;
      result.cur_day     <= day_next;
      result.cur_year    <= year_next;
      result.status      <= status;
      result.day_changed <= changed;
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.cur_hour    = result.cur_hour;
  assign result_out.cur_minute  = result.cur_minute;
  assign result_out.cur_second  = result.cur_second;
  assign result_out.cur_month   = result.cur_month;
  assign result_out.cur_day     = result.cur_day;
  assign result_out.cur_year    = result.cur_year;
  assign result_out.status      = result.status;
  assign result_out.day_changed = result.day_changed;

`ifndef SYNTHESIS
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    hour <= HOUR_MAX && minute <= MIN_MAX && second <= SEC_MAX)
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    month >= MON_FIRST && month <= MON_LAST && day >= DAY_FIRST)
    else $error("date out of range");

  a_result_is_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result.cur_year == year && result.cur_day == day &&
                  result.cur_month == month && result.cur_second == second)
    else $error("held result differs from state");

  a_refused_no_change: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.status != ST_OK |-> !result.day_changed)
    else $error("refused load reports a date change");

  a_tick_second: assert property (@(posedge clk) disable iff (rst)
    advance && s1_item.mode == MODE_TICK && second < SEC_MAX
    |=> second == $past(second) + SEC_W'(1) && minute == $past(minute))
    else $error("tick did not step the second");
`endif

endmodule

`default_nettype wire

// ----- rtl/time_and_calendar_counter.sv -----
// time_and_calendar_counter: top level, input register stage and calendar core
// depends on tcc_pkg, tcc_if, tcc_in_stage, tcc_calc
`default_nettype none

// 24-hour time of day plus Gregorian date, reset to 00:00:00 on 1/1/2000.
// Each item ticks one second, advances one day, loads all six fields, or with mode 3 does nothing;
// a refused load leaves the state alone and reports the first bad field.
// Throughput is one item per clock while the output is not stalled.
// An item is registered in the input register, and its result is then
// registered in the result register and offered on the output. A stalled
// output holds the result register and, through it, the input register.
// The leap-year rule uses a mod-25 residue of the year that is kept next
// to the year register and computed for load years on entry.
module time_and_calendar_counter (
  input  logic      clk,
  input  logic      rst,
  tcc_in_if.sink    item_in,
  tcc_out_if.source result_out
);
  import tcc_pkg::*;

  logic  s1_valid;
  item_t s1_item;
  logic  advance;

  tcc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .item_in  (item_in),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  tcc_calc u_calc (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item),
    .advance    (advance),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

// ----- test/tb_time_and_calendar_counter.sv -----
`timescale 1ns / 100ps
// tb_time_and_calendar_counter: self-checking bench for the time and calendar counter,
// a directed table of edge dates and bad loads, then random loads, tick and day bursts
// and no-op items; depends on tcc_pkg, tcc_if and time_and_calendar_counter

module tb_time_and_calendar_counter;
  import tcc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = MODE_W'(3);

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRESSURE_AT  = 120;
  localparam int HOLD_CYCLES  = 64;
  localparam int MAX_PRINTS   = 40;

  localparam int SRC_IDLE [4]    = '{0, 68, 0, 13};
  localparam int SNK_STALL [4]   = '{0, 0, 68, 13};
  localparam int PHASE_ITEMS [4] = '{450, 450, 450, 500};

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
    logic [YEAR_W-1:0] year;
  } cal_cmd_t;

  typedef struct {
    cal_cmd_t c;
    bit       typed;
    result_t  want;
  } plan_row_t;

  localparam result_t UNTYPED = '0;

  logic clk = 1'b0;
  logic rst;
  logic hold_off = 1'b0;

  tcc_in_if  item_bus ();
  tcc_out_if result_bus ();

  time_and_calendar_counter dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_bus),
    .result_out (result_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [HOUR_W-1:0] cal_hour;
  logic [MIN_W-1:0]  cal_minute;
  logic [SEC_W-1:0]  cal_second;
  logic [MON_W-1:0]  cal_month;
  logic [DAY_W-1:0]  cal_day;
  logic [YEAR_W-1:0] cal_year;

  result_t   expected_readings[$];
  plan_row_t plan[$];

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int mismatches    = 0;
  int refused_loads = 0;
  int date_changes  = 0;
  int cycle_count   = 0;

  function automatic int days_of_month(input logic [MON_W-1:0] mon,
                                       input logic [YEAR_W-1:0] yr);
    int y;
    y = int'(yr);
    case (int'(mon))
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11: return 30;
      2: return ((y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0))) ? 29 : 28;
      default: return 0;
    endcase
  endfunction

  function automatic void roll_date();
    if (int'(cal_day) >= days_of_month(cal_month, cal_year)) begin
      cal_day = DAY_FIRST;
      if (cal_month >= MON_LAST) begin
        cal_month = MON_FIRST;
        cal_year  = cal_year + 1'b1;
      end else begin
        cal_month = cal_month + 1'b1;
      end
    end else begin
      cal_day = cal_day + 1'b1;
    end
  endfunction

  function automatic result_t calendar_step(input cal_cmd_t c);
    result_t r;
    r = '0;
    r.status = ST_OK;
    r.day_changed = 1'b0;
    case (c.mode)
      MODE_TICK: begin
        if (cal_second >= SEC_MAX) begin
          cal_second = '0;
          if (cal_minute >= MIN_MAX) begin
            cal_minute = '0;
            if (cal_hour >= HOUR_MAX) begin
              cal_hour = '0;
              roll_date();
              r.day_changed = 1'b1;
            end else begin
              cal_hour = cal_hour + 1'b1;
            end
          end else begin
            cal_minute = cal_minute + 1'b1;
          end
        end else begin
          cal_second = cal_second + 1'b1;
        end
      end
      MODE_DAY: begin
        roll_date();
        r.day_changed = 1'b1;
      end
      MODE_LOAD: begin
        if (c.hour > HOUR_MAX) r.status = ST_BAD_HOUR;
        else if (c.minute > MIN_MAX) r.status = ST_BAD_MIN;
        else if (c.second > SEC_MAX) r.status = ST_BAD_SEC;
        else if (c.month < MON_FIRST || c.month > MON_LAST) r.status = ST_BAD_MON;
        else if (c.day < DAY_FIRST || int'(c.day) > days_of_month(c.month, c.year))
          r.status = ST_BAD_DAY;
        if (r.status == ST_OK) begin
          r.day_changed = (c.month != cal_month) || (c.day != cal_day) ||
                          (c.year != cal_year);
          cal_hour   = c.hour;
          cal_minute = c.minute;
          cal_second = c.second;
          cal_month  = c.month;
          cal_day    = c.day;
          cal_year   = c.year;
        end
      end
      default: ;
    endcase
    r.cur_hour   = cal_hour;
    r.cur_minute = cal_minute;
    r.cur_second = cal_second;
    r.cur_month  = cal_month;
    r.cur_day    = cal_day;
    r.cur_year   = cal_year;
    return r;
  endfunction

  function automatic cal_cmd_t cmd(input logic [MODE_W-1:0] m, input int h, input int mi,
                                   input int s, input int mo, input int d, input int y);
    cal_cmd_t c;
    c.mode   = m;
    c.hour   = HOUR_W'(h);
    c.minute = MIN_W'(mi);
    c.second = SEC_W'(s);
    c.month  = MON_W'(mo);
    c.day    = DAY_W'(d);
    c.year   = YEAR_W'(y);
    return c;
  endfunction

  function automatic result_t shows(input int h, input int mi, input int s, input int mo,
                                    input int d, input int y,
                                    input logic [STATUS_W-1:0] st, input bit dc);
    result_t r;
    r.cur_hour    = HOUR_W'(h);
    r.cur_minute  = MIN_W'(mi);
    r.cur_second  = SEC_W'(s);
    r.cur_month   = MON_W'(mo);
    r.cur_day     = DAY_W'(d);
    r.cur_year    = YEAR_W'(y);
    r.status      = st;
    r.day_changed = dc;
    return r;
  endfunction

  function automatic void row(input cal_cmd_t c, input bit typed, input result_t want);
    plan_row_t p;
    p.c = c;
    p.typed = typed;
    p.want = want;
    plan.push_back(p);
  endfunction

  function automatic cal_cmd_t random_fields(input logic [MODE_W-1:0] m);
    cal_cmd_t c;
    c.mode   = m;
    c.hour   = HOUR_W'($urandom);
    c.minute = MIN_W'($urandom);
    c.second = SEC_W'($urandom);
    c.month  = MON_W'($urandom);
    c.day    = DAY_W'($urandom);
    c.year   = YEAR_W'($urandom);
    return c;
  endfunction

  // well-formed load, biased toward midnight, month ends and century years
  function automatic cal_cmd_t valid_load();
    cal_cmd_t c;
    int len;
    c = random_fields(MODE_LOAD);
    c.hour   = $urandom_range(0, 1) ? HOUR_MAX : HOUR_W'($urandom_range(0, 23));
    c.minute = $urandom_range(0, 1) ? MIN_MAX : MIN_W'($urandom_range(0, 59));
    c.second = SEC_W'($urandom_range(0, 1) ? $urandom_range(50, 59) : $urandom_range(0, 59));
    c.month  = MON_W'($urandom_range(1, 12));
    case ($urandom_range(0, 4))
      0: c.year = YEAR_MAX - YEAR_W'($urandom_range(0, 1));
      1: c.year = YEAR_W'($urandom_range(0, 163) * 100);
      2: c.year = YEAR_W'($urandom_range(0, 40) * 400);
      3: c.year = YEAR_W'($urandom_range(0, 4095) * 4);
      default: ;
    endcase
    len = days_of_month(c.month, c.year);
    c.day = DAY_W'($urandom_range(0, 1) ? len - int'($urandom_range(0, 1))
                                        : int'($urandom_range(1, len)));
    return c;
  endfunction

  task automatic send_item(input cal_cmd_t c, input bit typed, input result_t want);
    result_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid       <= 1'b1;
    item_bus.mode        <= c.mode;
    item_bus.load_hour   <= c.hour;
    item_bus.load_minute <= c.minute;
    item_bus.load_second <= c.second;
    item_bus.load_month  <= c.month;
    item_bus.load_day    <= c.day;
    item_bus.load_year   <= c.year;
    do @(posedge clk); while (!item_bus.ready);
    pred = calendar_step(c);
    expected_readings.push_back(typed ? want : pred);
    sent_count++;
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] result %0d: %s", $realtime, checked_count, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic check_reading();
    result_t want;
    if (expected_readings.size() == 0) begin
      report_mismatch("result with no item pending");
    end else begin
      want = expected_readings.pop_front();
      compare_field("cur_hour", 32'(result_bus.cur_hour), 32'(want.cur_hour));
      compare_field("cur_minute", 32'(result_bus.cur_minute), 32'(want.cur_minute));
      compare_field("cur_second", 32'(result_bus.cur_second), 32'(want.cur_second));
      compare_field("cur_month", 32'(result_bus.cur_month), 32'(want.cur_month));
      compare_field("cur_day", 32'(result_bus.cur_day), 32'(want.cur_day));
      compare_field("cur_year", 32'(result_bus.cur_year), 32'(want.cur_year));
      compare_field("status", 32'(result_bus.status), 32'(want.status));
      compare_field("day_changed", 32'(result_bus.day_changed), 32'(want.day_changed));
      if (want.status != ST_OK) refused_loads++;
      if (want.day_changed) date_changes++;
      checked_count++;
    end
  endtask

  // result side
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_bus.valid && result_bus.ready) check_reading();
      result_bus.ready <= !hold_off && ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // long back-pressure stretch while the sender keeps offering
  initial begin
    wait (sent_count >= PRESSURE_AT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             expected_readings.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int pick;
    int burst;
    int work_count;
    int target;
    cal_cmd_t c;

    rst                  <= 1'b1;
    item_bus.valid       <= 1'b0;
    item_bus.mode        <= MODE_TICK;
    item_bus.load_hour   <= '0;
    item_bus.load_minute <= '0;
    item_bus.load_second <= '0;
    item_bus.load_month  <= '0;
    item_bus.load_day    <= '0;
    item_bus.load_year   <= '0;

    cal_hour   = '0;
    cal_minute = '0;
    cal_second = '0;
    cal_month  = MON_FIRST;
    cal_day    = DAY_FIRST;
    cal_year   = YEAR_RST;

    row(cmd(MODE_TICK, 0, 0, 0, 0, 0, 0), 1'b1, shows(0, 0, 1, 1, 1, 2000, ST_OK, 0));
    row(cmd(MODE_NONE, 31, 63, 63, 15, 31, 16383), 1'b1,
        shows(0, 0, 1, 1, 1, 2000, ST_OK, 0));
    row(cmd(MODE_LOAD, 31, 63, 63, 15, 31, 16383), 1'b1,
        shows(0, 0, 1, 1, 1, 2000, ST_BAD_HOUR, 0));
    row(cmd(MODE_LOAD, 23, 60, 63, 15, 31, 16383), 1'b1,
        shows(0, 0, 1, 1, 1, 2000, ST_BAD_MIN, 0));
    row(cmd(MODE_LOAD, 0, 59, 63, 0, 0, 0), 1'b1,
        shows(0, 0, 1, 1, 1, 2000, ST_BAD_SEC, 0));
    row(cmd(MODE_LOAD, 0, 0, 0, 0, 1, 2000), 1'b1,
        shows(0, 0, 1, 1, 1, 2000, ST_BAD_MON, 0));
    row(cmd(MODE_LOAD, 23, 59, 59, 13, 1, 2000), 1'b1,
        shows(0, 0, 1, 1, 1, 2000, ST_BAD_MON, 0));
    row(cmd(MODE_LOAD, 0, 0, 0, 1, 0, 2000), 1'b1,
        shows(0, 0, 1, 1, 1, 2000, ST_BAD_DAY, 0));
    row(cmd(MODE_LOAD, 0, 0, 0, 4, 31, 2000), 1'b1,
        shows(0, 0, 1, 1, 1, 2000, ST_BAD_DAY, 0));
    row(cmd(MODE_LOAD, 0, 0, 0, 2, 29, 1900), 1'b1,
        shows(0, 0, 1, 1, 1, 2000, ST_BAD_DAY, 0));
    row(cmd(MODE_LOAD, 0, 0, 0, 2, 30, 2000), 1'b1,
        shows(0, 0, 1, 1, 1, 2000, ST_BAD_DAY, 0));
    row(cmd(MODE_LOAD, 23, 59, 59, 12, 31, 16383), 1'b1,
        shows(23, 59, 59, 12, 31, 16383, ST_OK, 1));
    row(cmd(MODE_TICK, 0, 0, 0, 0, 0, 0), 1'b1, shows(0, 0, 0, 1, 1, 0, ST_OK, 1));
    row(cmd(MODE_LOAD, 23, 59, 59, 2, 28, 2000), 1'b1,
        shows(23, 59, 59, 2, 28, 2000, ST_OK, 1));
    row(cmd(MODE_TICK, 0, 0, 0, 0, 0, 0), 1'b1, shows(0, 0, 0, 2, 29, 2000, ST_OK, 1));
    row(cmd(MODE_DAY, 0, 0, 0, 0, 0, 0), 1'b1, shows(0, 0, 0, 3, 1, 2000, ST_OK, 1));
    row(cmd(MODE_LOAD, 0, 0, 0, 2, 29, 2100), 1'b1,
        shows(0, 0, 0, 3, 1, 2000, ST_BAD_DAY, 0));
    row(cmd(MODE_LOAD, 12, 30, 45, 2, 28, 2100), 1'b1,
        shows(12, 30, 45, 2, 28, 2100, ST_OK, 1));
    row(cmd(MODE_DAY, 0, 0, 0, 0, 0, 0), 1'b1, shows(12, 30, 45, 3, 1, 2100, ST_OK, 1));
    row(cmd(MODE_LOAD, 0, 0, 0, 3, 1, 2100), 1'b1, shows(0, 0, 0, 3, 1, 2100, ST_OK, 0));
    row(cmd(MODE_LOAD, 10, 59, 59, 2, 29, 2024), 1'b0, UNTYPED);
    row(cmd(MODE_TICK, 31, 63, 63, 15, 31, 16383), 1'b0, UNTYPED);
    row(cmd(MODE_LOAD, 23, 59, 59, 4, 30, 1999), 1'b0, UNTYPED);
    row(cmd(MODE_TICK, 0, 0, 0, 0, 0, 0), 1'b0, UNTYPED);
    row(cmd(MODE_LOAD, 0, 0, 0, 1, 1, 0), 1'b0, UNTYPED);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_item(plan[i].c, plan[i].typed, plan[i].want);

    work_count = 0;
    for (int p = 0; p < 4; p++) begin
      src_idle_pct = SRC_IDLE[p];
      snk_stall_pct <= SNK_STALL[p];
      target = work_count + PHASE_ITEMS[p];
      while (work_count < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          // load near a boundary, then a run of ticks and day steps across it
          send_item(valid_load(), 1'b0, UNTYPED);
          work_count++;
          burst = $urandom_range(1, 12);
          repeat (burst) begin
            c = random_fields(($urandom_range(0, 3) == 0) ? MODE_DAY : MODE_TICK);
            send_item(c, 1'b0, UNTYPED);
            work_count++;
          end
        end else if (pick < 93) begin
          send_item(random_fields(MODE_LOAD), 1'b0, UNTYPED);
          work_count++;
        end else begin
          send_item(random_fields(MODE_NONE), 1'b0, UNTYPED);
        end
      end
    end

    item_bus.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items over four idle/stall phases and one long hold-off;",
             sent_count);
    $display("compared %0d results, %0d refused loads, %0d date changes",
             checked_count, refused_loads, date_changes);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
